// File: hw/rtl/iiq_pkg.sv
// iiq_pkg: shared types, sizes and codes for the indexed insert queue.
// Depends on nothing; used by indexed_insert_queue.sv and the testbench.
package iiq_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int ST_W     = 2;
    localparam int FILL_W   = 5;
    localparam int CMPW     = (CW > POS_W) ? CW : POS_W;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PULL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_cmd_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [ST_W-1:0]          status;
        logic [FILL_W-1:0]        fill_count;
    } t_result_beat;

    // logical index (0 = head) to physical slot of the circular store
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(idx);
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return AW'(sum);
    endfunction

endpackage

// File: hw/rtl/iiq_ram.sv
// iiq_ram: simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
module iiq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/indexed_insert_queue.sv
// indexed_insert_queue: bounded queue with push, pull, peek, positional insert, clear.
// Depends on iiq_pkg and iiq_ram (circular entry store).
//
//  channel   handshake              payload
//  command   start & !busy          i_item   (t_cmd_beat)
//  result    o_valid, one cycle     o_result (t_result_beat)
//
// Push, clear, tail insert, unused codes, failed commands: result the cycle after acceptance, busy stays low.
// Pull and peek: the RAM read is issued at acceptance and S_READ registers its read data as the result.
// Insert: S_SHIFT moves one entry per cycle through the RAM, then S_PLACE writes the new value.
// Reset clears state, count, head and the control flags; the store needs no clearing pass.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
module indexed_insert_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  iiq_pkg::t_cmd_beat    i_item,
    output logic                  o_valid,
    output iiq_pkg::t_result_beat o_result
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SHIFT, S_PLACE} t_state;

    t_state                       r_state, n_state;
    logic [iiq_pkg::AW-1:0]       r_head, n_head;
    logic [iiq_pkg::CW-1:0]       r_count, n_count;
    logic [iiq_pkg::CW-1:0]       r_rd_idx, n_rd_idx;
    logic                         r_rd_go, n_rd_go;
    logic [iiq_pkg::CW-1:0]       r_wr_idx, n_wr_idx;
    logic                         r_wr_pend, n_wr_pend;
    logic [iiq_pkg::CW-1:0]       r_pos, n_pos;
    logic [iiq_pkg::DATA_W-1:0]   r_value, n_value;
    logic                         r_valid, n_valid;
    iiq_pkg::t_result_beat        r_result, n_result;

    logic                         ram_we;
    logic [iiq_pkg::AW-1:0]       ram_waddr, ram_raddr;
    logic [iiq_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;

    logic                         accept;
    logic                         full;
    logic [iiq_pkg::CMPW-1:0]     pos_ext, cnt_ext;
    logic [iiq_pkg::CW-1:0]       pos_t;

    assign accept  = start && (r_state == S_IDLE);
    assign full    = (r_count == iiq_pkg::CW'(iiq_pkg::CAPACITY));
    assign pos_ext = iiq_pkg::CMPW'(i_item.position);
    assign cnt_ext = iiq_pkg::CMPW'(r_count);
    assign pos_t   = iiq_pkg::CW'(i_item.position);

    iiq_ram #(
        .DEPTH(iiq_pkg::CAPACITY),
        .WIDTH(iiq_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_rd_go   = r_rd_go;
        n_wr_idx  = r_wr_idx;
        n_wr_pend = r_wr_pend;
        n_pos     = r_pos;
        n_value   = r_value;
        n_valid   = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = iiq_pkg::phys_addr(r_head, r_wr_idx);
        ram_wdata = ram_rdata;
        ram_raddr = iiq_pkg::phys_addr(r_head, r_rd_idx);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid             = 1'b1;
                    n_result.read_value = '0;
                    n_result.status     = iiq_pkg::ST_OK;
                    n_result.fill_count = iiq_pkg::FILL_W'(r_count);
                    unique case (i_item.cmd)
                        iiq_pkg::CMD_PUSH: begin
                            if (full) begin
                                n_result.status = iiq_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = iiq_pkg::phys_addr(r_head, r_count);
                                ram_wdata = i_item.value;
                                n_count   = r_count + iiq_pkg::CW'(1);
                                n_result.fill_count = iiq_pkg::FILL_W'(n_count);
                            end
                        end
                        iiq_pkg::CMD_PULL: begin
                            if (r_count == '0) begin
                                n_result.status = iiq_pkg::ST_EMPTY;
                            end else begin
                                n_valid   = 1'b0;
                                ram_raddr = r_head;
                                n_head    = iiq_pkg::phys_addr(r_head, iiq_pkg::CW'(1));
                                n_count   = r_count - iiq_pkg::CW'(1);
                                n_state   = S_READ;
                            end
                        end
                        iiq_pkg::CMD_PEEK: begin
                            if (pos_ext < cnt_ext) begin
                                n_valid   = 1'b0;
                                ram_raddr = iiq_pkg::phys_addr(r_head, pos_t);
                                n_state   = S_READ;
                            end else begin
                                n_result.status = iiq_pkg::ST_RANGE;
                            end
                        end
                        iiq_pkg::CMD_INSERT: begin
                            if (full) begin
                                n_result.status = iiq_pkg::ST_FULL;
                            end else if (pos_ext != '0 && pos_ext >= cnt_ext) begin
                                n_result.status = iiq_pkg::ST_RANGE;
                            end else if (pos_t == r_count) begin
                                ram_we    = 1'b1;
                                ram_waddr = iiq_pkg::phys_addr(r_head, pos_t);
                                ram_wdata = i_item.value;
                                n_count   = r_count + iiq_pkg::CW'(1);
                                n_result.fill_count = iiq_pkg::FILL_W'(n_count);
                            end else begin
                                n_valid   = 1'b0;
                                n_rd_idx  = r_count - iiq_pkg::CW'(1);
                                n_rd_go   = 1'b1;
                                n_wr_pend = 1'b0;
                                n_pos     = pos_t;
                                n_value   = i_item.value;
                                n_state   = S_SHIFT;
                            end
                        end
                        iiq_pkg::CMD_CLEAR: begin
                            n_count             = '0;
                            n_result.fill_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid             = 1'b1;
                n_result.read_value = ram_rdata;
                n_result.status     = iiq_pkg::ST_OK;
                n_result.fill_count = iiq_pkg::FILL_W'(r_count);
                n_state             = S_IDLE;
            end
            S_SHIFT: begin
                // read idx k while writing idx k+2 from the previous read
                ram_we = r_wr_pend;
                if (r_rd_go) begin
                    n_wr_pend = 1'b1;
                    n_wr_idx  = r_rd_idx + iiq_pkg::CW'(1);
                    if (r_rd_idx == r_pos) begin
                        n_rd_go = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx - iiq_pkg::CW'(1);
                    end
                end else begin
                    n_wr_pend = 1'b0;
                    n_state   = S_PLACE;
                end
            end
            S_PLACE: begin
                ram_we              = 1'b1;
                ram_waddr           = iiq_pkg::phys_addr(r_head, r_pos);
                ram_wdata           = r_value;
                n_count             = r_count + iiq_pkg::CW'(1);
                n_valid             = 1'b1;
                n_result.read_value = '0;
                n_result.status     = iiq_pkg::ST_OK;
                n_result.fill_count = iiq_pkg::FILL_W'(n_count);
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_rd_go   <= 1'b0;
            r_wr_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_rd_go   <= n_rd_go;
            r_wr_pend <= n_wr_pend;
            r_valid   <= n_valid;
        end
        r_rd_idx <= n_rd_idx;
        r_wr_idx <= n_wr_idx;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iiq_pkg::CW'(iiq_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.cmd == iiq_pkg::CMD_PUSH && full
        |=> o_valid && o_result.status == iiq_pkg::ST_FULL && $stable(r_count))
        else $error("push into full queue not refused");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.cmd == iiq_pkg::CMD_CLEAR |=> o_valid && o_result.fill_count == '0)
        else $error("clear did not empty the queue");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT && r_rd_go |-> r_rd_idx >= r_pos && r_rd_idx < r_count)
        else $error("shift read index outside the moved range");

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for indexed_insert_queue, with a queue-order predictor,
// a backlog-fed command driver and a result monitor. Needs iiq_pkg and the queue RTL.
module testbench;

    typedef struct {
        iiq_pkg::t_cmd_beat beat;
        bit                 drain_first;
    } t_backlog_entry;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    iiq_pkg::t_cmd_beat    i_item  = '0;
    logic                  busy;
    logic                  o_valid;
    iiq_pkg::t_result_beat o_result;

    t_backlog_entry        cmd_backlog[$];
    iiq_pkg::t_result_beat pending_results[$];

    logic signed [iiq_pkg::DATA_W-1:0] queue_store [iiq_pkg::CAPACITY];
    int queue_fill    = 0;
    int gen_fill      = 0;
    int issued_cmds   = 0;
    int accepted_cmds = 0;
    int fail_count    = 0;

    indexed_insert_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // predicted effect of one command on the queue, head at slot 0
    function automatic iiq_pkg::t_result_beat apply_queue_op(input iiq_pkg::t_cmd_beat c);
        iiq_pkg::t_result_beat r;
        int pos;
        int i;
        r.read_value = '0;
        r.status     = iiq_pkg::ST_OK;
        pos          = int'(c.position);
        case (c.cmd)
            iiq_pkg::CMD_PUSH: begin
                if (queue_fill >= iiq_pkg::CAPACITY) begin
                    r.status = iiq_pkg::ST_FULL;
                end else begin
                    queue_store[queue_fill] = c.value;
                    queue_fill++;
                end
            end
            iiq_pkg::CMD_PULL: begin
                if (queue_fill == 0) begin
                    r.status = iiq_pkg::ST_EMPTY;
                end else begin
                    r.read_value = queue_store[0];
                    for (i = 1; i < queue_fill; i++) queue_store[i-1] = queue_store[i];
                    queue_fill--;
                end
            end
            iiq_pkg::CMD_PEEK: begin
                if (pos < queue_fill) begin
                    r.read_value = queue_store[pos];
                end else begin
                    r.status = iiq_pkg::ST_RANGE;
                end
            end
            iiq_pkg::CMD_INSERT: begin
                if (queue_fill >= iiq_pkg::CAPACITY) begin
                    r.status = iiq_pkg::ST_FULL;
                end else if (pos != 0 && pos >= queue_fill) begin
                    r.status = iiq_pkg::ST_RANGE;
                end else begin
                    for (i = queue_fill; i > pos; i--) queue_store[i] = queue_store[i-1];
                    queue_store[pos] = c.value;
                    queue_fill++;
                end
            end
            iiq_pkg::CMD_CLEAR: begin
                queue_fill = 0;
            end
            default: begin
            end
        endcase
        r.fill_count = iiq_pkg::FILL_W'(queue_fill);
        return r;
    endfunction

    // shadow fill level lets the generator aim positions at live entries
    task automatic add_cmd(input logic [iiq_pkg::CMD_W-1:0] cmd,
                           input logic [iiq_pkg::DATA_W-1:0] value,
                           input int pos, input bit drain);
        t_backlog_entry e;
        e.beat.cmd      = cmd;
        e.beat.value    = value;
        e.beat.position = iiq_pkg::POS_W'(pos);
        e.drain_first   = drain;
        cmd_backlog.push_back(e);
        issued_cmds++;
        case (cmd)
            iiq_pkg::CMD_PUSH:   if (gen_fill < iiq_pkg::CAPACITY) gen_fill++;
            iiq_pkg::CMD_PULL:   if (gen_fill > 0) gen_fill--;
            iiq_pkg::CMD_INSERT:
                if (gen_fill < iiq_pkg::CAPACITY && (pos == 0 || pos < gen_fill)) gen_fill++;
            iiq_pkg::CMD_CLEAR:  gen_fill = 0;
            default: begin
            end
        endcase
    endtask

    function automatic logic [iiq_pkg::DATA_W-1:0] pick_value();
        logic [iiq_pkg::DATA_W-1:0] extremes [4];
        extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        if ($urandom_range(0, 9) == 0) return extremes[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    // driver: one beat per accepted start, idling at random outside a quiet window
    always @(posedge i_clk) begin
        bit present;
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            if (start && !busy) begin
                pending_results.push_back(apply_queue_op(i_item));
                void'(cmd_backlog.pop_front());
                accepted_cmds++;
            end
            present = (cmd_backlog.size() != 0);
            if (present && cmd_backlog[0].drain_first && pending_results.size() != 0)
                present = 1'b0;
            if (present && (accepted_cmds < 700 || accepted_cmds > 1100)
                    && $urandom_range(0, 99) < 32)
                present = 1'b0;
            start <= present;
            if (present) i_item <= cmd_backlog[0].beat;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        iiq_pkg::t_result_beat exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: read_value %0d status %0d fill_count %0d",
                       o_result.read_value, o_result.status, o_result.fill_count);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result.read_value !== exp_r.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           exp_r.read_value, o_result.read_value);
                    fail_count++;
                end
                if (o_result.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_result.status);
                    fail_count++;
                end
                if (o_result.fill_count !== exp_r.fill_count) begin
                    $error("fill_count: expected %0d, got %0d",
                           exp_r.fill_count, o_result.fill_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int mode;
        int burst_len;
        int r;
        int pos;
        logic [iiq_pkg::CMD_W-1:0] cmd;

        // directed: empty-queue failures, insert into empty, extremes, unused codes
        add_cmd(iiq_pkg::CMD_PULL,   32'h0, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_PEEK,   32'h0, 15, 1'b0);
        add_cmd(iiq_pkg::CMD_PEEK,   32'h0, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_INSERT, 32'h1234_5678, 3, 1'b0);
        add_cmd(iiq_pkg::CMD_INSERT, 32'h8000_0000, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_PEEK,   32'h0, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_PUSH,   32'h7fff_ffff, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_PEEK,   32'h0, 1, 1'b0);
        add_cmd(iiq_pkg::CMD_INSERT, 32'hffff_ffff, 1, 1'b0);
        add_cmd(iiq_pkg::CMD_INSERT, 32'h0, 3, 1'b0);
        add_cmd(iiq_pkg::CMD_INSERT, 32'h5555_aaaa, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_PEEK,   32'h0, 3, 1'b0);
        add_cmd(iiq_pkg::CMD_PEEK,   32'h0, 4, 1'b0);
        add_cmd(iiq_pkg::CMD_PEEK,   32'h0, 15, 1'b0);
        add_cmd(3'd5,                32'hdead_beef, 2, 1'b0);
        add_cmd(3'd6,                32'hffff_ffff, 15, 1'b0);
        add_cmd(3'd7,                32'h0, 7, 1'b0);
        add_cmd(iiq_pkg::CMD_PULL,   32'h0, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_PULL,   32'h0, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_CLEAR,  32'hffff_ffff, 15, 1'b0);
        add_cmd(iiq_pkg::CMD_PULL,   32'h0, 0, 1'b0);
        add_cmd(iiq_pkg::CMD_PUSH,   32'h0000_0001, 0, 1'b0);

        // random bursts, each biased to fill, drain or mix the queue
        while (issued_cmds < 1970) begin
            mode      = $urandom_range(0, 2);
            burst_len = $urandom_range(5, 60);
            repeat (burst_len) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: cmd = (r < 45) ? iiq_pkg::CMD_PUSH : (r < 75) ? iiq_pkg::CMD_INSERT
                           : (r < 85) ? iiq_pkg::CMD_PEEK : (r < 95) ? iiq_pkg::CMD_PULL
                           : (r < 97) ? iiq_pkg::CMD_CLEAR : 3'd5;
                    1: cmd = (r < 15) ? iiq_pkg::CMD_PUSH : (r < 25) ? iiq_pkg::CMD_INSERT
                           : (r < 45) ? iiq_pkg::CMD_PEEK : (r < 92) ? iiq_pkg::CMD_PULL
                           : (r < 94) ? iiq_pkg::CMD_CLEAR : 3'd5;
                    default: cmd = (r < 25) ? iiq_pkg::CMD_PUSH
                           : (r < 45) ? iiq_pkg::CMD_INSERT
                           : (r < 65) ? iiq_pkg::CMD_PEEK : (r < 90) ? iiq_pkg::CMD_PULL
                           : (r < 93) ? iiq_pkg::CMD_CLEAR : 3'd5;
                endcase
                if (cmd == 3'd5) cmd = iiq_pkg::CMD_W'($urandom_range(5, 7));
                if ($urandom_range(0, 3) == 0 || gen_fill == 0)
                    pos = $urandom_range(0, 15);
                else
                    pos = $urandom_range(0, gen_fill - 1);
                add_cmd(cmd, pick_value(), pos,
                        issued_cmds == 30 || issued_cmds == 990);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
